// ----- hw/rtl/tournament_branch_predictor_defines.svh -----
// Assertion macros shared by the tournament branch predictor RTL.
`ifndef TOURNAMENT_BRANCH_PREDICTOR_DEFINES_SVH
`define TOURNAMENT_BRANCH_PREDICTOR_DEFINES_SVH

`ifndef SYNTH
// Check a condition or implication at every clock edge out of reset.
`define TBP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Check that a trigger is followed in the next cycle by a condition.
`define TBP_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);
`else
`define TBP_ASSERT(lbl, prop, msg)
`define TBP_ASSERT_NEXT(lbl, pre, post, msg)
`endif

`endif

// ----- hw/rtl/tbp_pkg.sv -----
// Shared types, constants and counter helpers for the tournament branch predictor.
package tbp_pkg;

  localparam int HISTORY_BITS_DEF = 13;
  localparam int BIMODAL_BITS_DEF = 12;

  localparam int CTR_W       = 2;
  localparam int PC_W        = 32;
  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 8;
  localparam int PC_LSB      = 0;
  localparam int OUTCOME_BIT = 32;

  typedef logic [CTR_W-1:0] ctr_t;

  localparam ctr_t CTR_MAX       = 2'd3;
  localparam ctr_t CTR_MIN       = 2'd0;
  localparam ctr_t CTR_TAKEN_MIN = 2'd2;

  typedef enum logic {
    KIND_PREDICT = 1'b0,
    KIND_TRAIN   = 1'b1
  } kind_t;

  // Move a 2-bit counter one step toward the given direction, saturating.
  function automatic ctr_t sat_step(ctr_t c, logic up);
    ctr_t r;
    if (up) begin
      r = (c == CTR_MAX) ? c : ctr_t'(c + ctr_t'(1));
    end else begin
      r = (c == CTR_MIN) ? c : ctr_t'(c - ctr_t'(1));
    end
    return r;
  endfunction

  function automatic logic ctr_taken(ctr_t c);
    return (c >= CTR_TAKEN_MIN);
  endfunction

endpackage

// ----- hw/rtl/tbp_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module tbp_ram #(
  parameter int WIDTH = tbp_pkg::CTR_W,
  parameter int DEPTH = 1 << tbp_pkg::BIMODAL_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- hw/rtl/tbp_clear.sv -----
// Post-reset sweep sequencer that walks every table address once.
module tbp_clear #(
  parameter int ADDR_W = tbp_pkg::HISTORY_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  output logic              busy,
  output logic [ADDR_W-1:0] addr
);

  logic              busy_r;
  logic [ADDR_W-1:0] addr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b1;
      addr_r <= '0;
    end else if (busy_r) begin
      addr_r <= addr_r + ADDR_W'(1);
      if (addr_r == '1) begin
        busy_r <= 1'b0;
      end
    end
  end

  assign busy = busy_r;
  assign addr = addr_r;

endmodule

// ----- hw/rtl/tournament_branch_predictor.sv -----
// Top level of the tournament (gshare plus bimodal) branch predictor.
//
// Input channel (in_*): one transaction per branch event. in_tuser carries the
// kind (predict or train); in_tdata carries the pc and the resolved outcome.
// A predict transaction yields exactly one result transaction on out_* whose
// out_tdata bit 0 is the predicted direction; a train transaction yields none.
// Path: a predict is accepted and its tables are read into the stage register;
// its direction then moves to the output register, which drives out_tvalid.
// Throughput: one transaction per cycle outside the sweep and output stalls,
// set by the single read and write port of each table RAM; the chooser
// read-modify-write and a back-to-back predict after a train are served by a
// one-entry write bypass per table.
// Reset: rst_n (synchronous, active low) clears the history, the held indices
// and counts and the pipeline; then a sweep writes zero to every table entry,
// one address per cycle, over 2^max(HISTORY_BITS, BIMODAL_BITS) addresses
// (8192 at the default sizes), while in_tready stays low.
// Stall: while out_tready is low a finished prediction holds in the output
// register; the stage behind it still takes one more transaction, and a train
// there completes without waiting on the output side.
module tournament_branch_predictor #(
  parameter int HISTORY_BITS = tbp_pkg::HISTORY_BITS_DEF,
  parameter int BIMODAL_BITS = tbp_pkg::BIMODAL_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [tbp_pkg::IN_TDATA_W-1:0]   in_tdata,   // [31:0] pc, [32] outcome, rest zero
  input  logic [0:0]                       in_tuser,   // [0] kind
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [tbp_pkg::OUT_TDATA_W-1:0]  out_tdata   // [0] taken, rest zero
);

  import tbp_pkg::*;
  `include "tournament_branch_predictor_defines.svh"

  localparam int HB       = HISTORY_BITS;
  localparam int BB       = BIMODAL_BITS;
  localparam int CLR_BITS = (HB > BB) ? HB : BB;

  // Sweep sequencer
  logic                clr_busy;
  logic [CLR_BITS-1:0] clr_addr;

  tbp_clear #(.ADDR_W(CLR_BITS)) u_clear (
    .clk   (clk),
    .rst_n (rst_n),
    .busy  (clr_busy),
    .addr  (clr_addr)
  );

  // Unpack the input transaction
  logic [PC_W-1:0] in_pc;
  logic            in_outcome;
  kind_t           in_kind;

  assign in_pc      = in_tdata[PC_LSB +: PC_W];
  assign in_outcome = in_tdata[OUTCOME_BIT];
  assign in_kind    = kind_t'(in_tuser[0]);

  // Stage register (holds the item while its table reads come back)
  logic          s1_valid_r;
  kind_t         s1_kind_r;
  logic          s1_outcome_r;
  logic [HB-1:0] s1_gi_r;
  logic [BB-1:0] s1_bi_r;
  logic [BB-1:0] s1_ci_r;

  // Architectural state
  logic [HB-1:0] hist_r;
  logic [HB-1:0] held_gi_r;
  logic [BB-1:0] held_bi_r;
  ctr_t          held_gc_r;
  ctr_t          held_bc_r;

  // One-entry write bypass per table, captured in the cycle the stage item was read
  logic          byp_g_we_r, byp_b_we_r, byp_c_we_r;
  logic [HB-1:0] byp_g_addr_r;
  logic [BB-1:0] byp_b_addr_r, byp_c_addr_r;
  ctr_t          byp_g_data_r, byp_b_data_r, byp_c_data_r;

  // Output register
  logic out_valid_r;
  logic out_taken_r;

  // Handshake and stage control
  logic s1_train, s1_pred, out_free, s1_pred_done, s1_done, in_fire;

  assign s1_train     = s1_valid_r && (s1_kind_r == KIND_TRAIN);
  assign s1_pred      = s1_valid_r && (s1_kind_r == KIND_PREDICT);
  assign out_free     = !out_valid_r || out_tready;
  assign s1_pred_done = s1_pred && out_free;
  assign s1_done      = s1_train || s1_pred_done;
  assign in_tready    = !clr_busy && (!s1_valid_r || s1_done);
  assign in_fire      = in_tvalid && in_tready;

  // Read addresses: forward history and held index from the item that leaves now
  logic [HB-1:0] hist_fwd, gi0, held_gi_fwd, ch_src_gi;
  logic [BB-1:0] bi0, ci0;

  assign hist_fwd    = s1_train ? {hist_r[HB-2:0], s1_outcome_r} : hist_r;
  assign gi0         = hist_fwd ^ in_pc[HB-1:0];
  assign bi0         = in_pc[BB-1:0];
  assign held_gi_fwd = s1_pred_done ? s1_gi_r : held_gi_r;
  assign ch_src_gi   = (in_kind == KIND_TRAIN) ? held_gi_fwd : gi0;

  // Chooser index is the low bimodal-width bits of the gshare index
  generate
    if (HB >= BB) begin : g_ci_trunc
      assign ci0 = ch_src_gi[BB-1:0];
    end else begin : g_ci_ext
      assign ci0 = {{(BB - HB){1'b0}}, ch_src_gi};
    end
  endgenerate

  // Table RAMs
  ctr_t          g_rd, b_rd, c_rd;
  logic          gs_we, bm_we, ch_we;
  logic [HB-1:0] gs_waddr;
  logic [BB-1:0] bm_waddr, ch_waddr;
  ctr_t          gs_wdata, bm_wdata, ch_wdata;

  tbp_ram #(.WIDTH(CTR_W), .DEPTH(1 << HB)) u_gshare (
    .clk (clk), .we (gs_we), .waddr (gs_waddr), .wdata (gs_wdata),
    .re (in_fire), .raddr (gi0), .rdata (g_rd)
  );

  tbp_ram #(.WIDTH(CTR_W), .DEPTH(1 << BB)) u_bimodal (
    .clk (clk), .we (bm_we), .waddr (bm_waddr), .wdata (bm_wdata),
    .re (in_fire), .raddr (bi0), .rdata (b_rd)
  );

  tbp_ram #(.WIDTH(CTR_W), .DEPTH(1 << BB)) u_chooser (
    .clk (clk), .we (ch_we), .waddr (ch_waddr), .wdata (ch_wdata),
    .re (in_fire), .raddr (ci0), .rdata (c_rd)
  );

  // Counters seen by the stage item, patched with the write made during its read
  ctr_t gc, bc, ch;
  logic taken;

  assign gc    = (byp_g_we_r && (byp_g_addr_r == s1_gi_r)) ? byp_g_data_r : g_rd;
  assign bc    = (byp_b_we_r && (byp_b_addr_r == s1_bi_r)) ? byp_b_data_r : b_rd;
  assign ch    = (byp_c_we_r && (byp_c_addr_r == s1_ci_r)) ? byp_c_data_r : c_rd;
  assign taken = ctr_taken(ch) ? ctr_taken(gc) : ctr_taken(bc);

  // Training: step the chooser toward the right table only when they disagreed
  logic gp, bp, disagree;

  assign gp       = ctr_taken(held_gc_r);
  assign bp       = ctr_taken(held_bc_r);
  assign disagree = (gp != bp);

  // Write ports: the reset sweep writes zero, otherwise a leaving train writes
  assign gs_we    = clr_busy || s1_train;
  assign gs_waddr = clr_busy ? clr_addr[HB-1:0] : held_gi_r;
  assign gs_wdata = clr_busy ? CTR_MIN : sat_step(held_gc_r, s1_outcome_r);

  assign bm_we    = clr_busy || s1_train;
  assign bm_waddr = clr_busy ? clr_addr[BB-1:0] : held_bi_r;
  assign bm_wdata = clr_busy ? CTR_MIN : sat_step(held_bc_r, s1_outcome_r);

  assign ch_we    = clr_busy || (s1_train && disagree);
  assign ch_waddr = clr_busy ? clr_addr[BB-1:0] : s1_ci_r;
  assign ch_wdata = clr_busy ? CTR_MIN : sat_step(ch, gp == s1_outcome_r);

  // Control and architectural state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      hist_r      <= '0;
      held_gi_r   <= '0;
      held_bi_r   <= '0;
      held_gc_r   <= CTR_MIN;
      held_bc_r   <= CTR_MIN;
      byp_g_we_r  <= 1'b0;
      byp_b_we_r  <= 1'b0;
      byp_c_we_r  <= 1'b0;
    end else begin
      if (in_fire) begin
        s1_valid_r <= 1'b1;
      end else if (s1_done) begin
        s1_valid_r <= 1'b0;
      end

      if (s1_pred_done) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end

      // Shift the resolved direction into the history
      if (s1_train) begin
        hist_r <= {hist_r[HB-2:0], s1_outcome_r};
      end

      // Latch what the next train will update
      if (s1_pred_done) begin
        held_gi_r <= s1_gi_r;
        held_bi_r <= s1_bi_r;
        held_gc_r <= gc;
        held_bc_r <= bc;
      end

      if (in_fire) begin
        byp_g_we_r <= gs_we;
        byp_b_we_r <= bm_we;
        byp_c_we_r <= ch_we;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_kind_r    <= in_kind;
      s1_outcome_r <= in_outcome;
      s1_gi_r      <= gi0;
      s1_bi_r      <= bi0;
      s1_ci_r      <= ci0;
      byp_g_addr_r <= gs_waddr;
      byp_g_data_r <= gs_wdata;
      byp_b_addr_r <= bm_waddr;
      byp_b_data_r <= bm_wdata;
      byp_c_addr_r <= ch_waddr;
      byp_c_data_r <= ch_wdata;
    end
    if (s1_pred_done) begin
      out_taken_r <= taken;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_TDATA_W - 1){1'b0}}, out_taken_r};

  `TBP_ASSERT(a_no_accept_in_sweep, clr_busy |-> !in_fire, "transaction accepted during table sweep")
  `TBP_ASSERT_NEXT(a_train_leaves, s1_train && !in_fire, !s1_valid_r, "train item stuck in stage")
  `TBP_ASSERT_NEXT(a_pred_reaches_out, s1_pred_done, out_valid_r && (out_taken_r == $past(taken)), "prediction lost on its way out")
  `TBP_ASSERT_NEXT(a_hist_shift, s1_train, hist_r[0] == $past(s1_outcome_r), "history did not take the outcome")

endmodule

// ----- tb/sv/tournament_branch_predictor_tb.sv -----
// Self-checking stream testbench for the tournament branch predictor.
module tournament_branch_predictor_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import tbp_pkg::*;

  localparam int HIST_W     = HISTORY_BITS_DEF;
  localparam int BIMO_W     = BIMODAL_BITS_DEF;
  localparam int EVENT_GOAL = 700;
  localparam int HOLD_AFTER = 150;   // start the long receiver hold-off at this result
  localparam int HOLD_LEN   = 400;   // cycles of the long hold-off
  localparam int DRAIN_LEN  = 16;    // generous slack for the last result to drain

  typedef struct {
    kind_t       kind;
    logic [31:0] pc;
    logic        outcome;
  } branch_event_t;

  // Clock, reset and every block input start at known values.
  logic                   clk        = 1'b0;
  logic                   rst_n      = 1'b0;
  logic                   in_tvalid  = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata   = '0;  // [31:0] pc, [32] outcome, rest zero
  logic [0:0]             in_tuser   = '0;  // [0] kind
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;        // [0] taken, rest zero

  always #2 clk = ~clk;

  tournament_branch_predictor DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  // ---------------------------------------------------------------------------
  // Predictor state mirrored in the bench: three counter tables, the global
  // history and what the last prediction latched for the next training event.
  // ---------------------------------------------------------------------------
  ctr_t              gshare_ctr  [1 << HIST_W];
  ctr_t              bimodal_ctr [1 << BIMO_W];
  ctr_t              chooser_ctr [1 << BIMO_W];
  logic [HIST_W-1:0] ghist;
  logic [HIST_W-1:0] last_gidx;
  logic [BIMO_W-1:0] last_bidx;
  ctr_t              last_gcnt;
  ctr_t              last_bcnt;

  branch_event_t branch_events[$];   // events still to be offered
  logic          predicted_dirs[$];  // directions owed by the block, oldest first
  int            mismatches = 0;

  // Move a counter one step toward the direction, clamped to the 2-bit range.
  function automatic ctr_t nudge(ctr_t c, logic up);
    int v;
    v = int'(c) + (up ? 1 : -1);
    if (v < int'(CTR_MIN)) v = int'(CTR_MIN);
    if (v > int'(CTR_MAX)) v = int'(CTR_MAX);
    return ctr_t'(v);
  endfunction

  // Look up all three tables, latch indices and counts, return the direction.
  function automatic logic predict_dir(logic [31:0] pc);
    logic [HIST_W-1:0] gidx;
    logic [BIMO_W-1:0] bidx;
    ctr_t              sel;
    gidx      = ghist ^ pc[HIST_W-1:0];
    bidx      = pc[BIMO_W-1:0];
    sel       = chooser_ctr[gidx[BIMO_W-1:0]];
    last_gidx = gidx;
    last_bidx = bidx;
    last_gcnt = gshare_ctr[gidx];
    last_bcnt = bimodal_ctr[bidx];
    if (sel >= CTR_TAKEN_MIN) return last_gcnt >= CTR_TAKEN_MIN;
    return last_bcnt >= CTR_TAKEN_MIN;
  endfunction

  // Train from the latched lookup; the chooser itself is read fresh each time.
  task automatic train_tables(logic outcome);
    logic g_dir;
    logic b_dir;
    logic [BIMO_W-1:0] cidx;
    g_dir = last_gcnt >= CTR_TAKEN_MIN;
    b_dir = last_bcnt >= CTR_TAKEN_MIN;
    cidx  = last_gidx[BIMO_W-1:0];
    if (g_dir != b_dir) chooser_ctr[cidx] = nudge(chooser_ctr[cidx], g_dir == outcome);
    ghist = {ghist[HIST_W-2:0], outcome};
    gshare_ctr[last_gidx]  = nudge(last_gcnt, outcome);
    bimodal_ctr[last_bidx] = nudge(last_bcnt, outcome);
  endtask

  task automatic add_event(kind_t kind, logic [31:0] pc, logic outcome);
    branch_event_t ev;
    ev.kind    = kind;
    ev.pc      = pc;
    ev.outcome = outcome;
    branch_events.push_back(ev);
  endtask

  // ---------------------------------------------------------------------------
  // Driver: offer queued events, idle a random number of cycles between them.
  // Long calm stretches run back to back with no idling at all.
  // ---------------------------------------------------------------------------
  branch_event_t on_wire;
  int            send_wait = 0;
  logic          send_calm = 1'b0;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      send_wait = 0;
    end else begin
      if (in_tvalid && in_tready) begin
        // Update the mirror at the edge that moves the transaction.
        if (on_wire.kind == KIND_PREDICT) begin
          predicted_dirs.push_back(predict_dir(on_wire.pc));
        end else begin
          train_tables(on_wire.outcome);
        end
        if ($urandom_range(0, 39) == 0) send_calm = ~send_calm;
        send_wait = send_calm ? 0 : $urandom_range(0, 11);
      end
      // Hold a pending transaction until it is taken; otherwise advance.
      if (!in_tvalid || in_tready) begin
        if (send_wait > 0) begin
          send_wait--;
          in_tvalid <= 1'b0;
        end else if (branch_events.size() > 0) begin
          on_wire = branch_events.pop_front();
          in_tdata  <= {{(IN_TDATA_W - PC_W - 1){1'b0}}, on_wire.outcome, on_wire.pc};
          in_tuser  <= on_wire.kind;
          in_tvalid <= 1'b1;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: random stalls after each result, plus one long hold-off while the
  // driver keeps offering, so the pipeline backs up and drops in_tready.
  // ---------------------------------------------------------------------------
  int   recv_wait = 0;
  int   hold_cycles = 0;
  int   dirs_received = 0;
  logic hold_done = 1'b0;
  logic recv_calm = 1'b0;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      recv_wait = 0;
    end else if (hold_cycles > 0) begin
      hold_cycles--;
      out_tready <= (hold_cycles == 0);
    end else if (out_tvalid && out_tready) begin
      dirs_received++;
      if (!hold_done && dirs_received == HOLD_AFTER) begin
        hold_done = 1'b1;
        hold_cycles = HOLD_LEN;
        out_tready <= 1'b0;
      end else begin
        if ($urandom_range(0, 39) == 0) recv_calm = ~recv_calm;
        recv_wait = recv_calm ? 0 : $urandom_range(0, 11);
        out_tready <= (recv_wait == 0);
      end
    end else if (!out_tready) begin
      if (recv_wait > 0) recv_wait--;
      out_tready <= (recv_wait == 0);
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: compare each accepted result with the oldest predicted direction.
  // ---------------------------------------------------------------------------
  logic want_dir;

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (predicted_dirs.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: result with nothing outstanding, taken=%0b", $realtime, out_tdata[0]);
      end else begin
        want_dir = predicted_dirs.pop_front();
        if (out_tdata[0] !== want_dir) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: taken mismatch, expected %0b got %0b",
                     $realtime, want_dir, out_tdata[0]);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus, reset and end of run.
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    logic [31:0] hot_pc [16];
    int unsigned bias [16];
    int k;
    int pick;

    foreach (gshare_ctr[i])  gshare_ctr[i]  = CTR_MIN;
    foreach (bimodal_ctr[i]) bimodal_ctr[i] = CTR_MIN;
    foreach (chooser_ctr[i]) chooser_ctr[i] = CTR_MIN;
    ghist     = '0;
    last_gidx = '0;
    last_bidx = '0;
    last_gcnt = CTR_MIN;
    last_bcnt = CTR_MIN;

    // Train before any predict, and twice in a row, off the reset latches.
    add_event(KIND_TRAIN, 32'h0000_0000, 1'b1);
    add_event(KIND_TRAIN, 32'hFFFF_FFFF, 1'b0);
    // Extreme pcs; the predict outcome bit and the train pc must be ignored.
    add_event(KIND_PREDICT, 32'h0000_0000, 1'b0);
    add_event(KIND_PREDICT, 32'hFFFF_FFFF, 1'b1);
    add_event(KIND_TRAIN, 32'hFFFF_FFFF, 1'b1);
    add_event(KIND_TRAIN, 32'hA5A5_5A5A, 1'b1);
    // Saturate one branch upward, then walk it back down.
    repeat (5) begin
      add_event(KIND_PREDICT, 32'h0000_1234, 1'b1);
      add_event(KIND_TRAIN, 32'h0000_0000, 1'b1);
    end
    repeat (3) begin
      add_event(KIND_PREDICT, 32'h0000_1234, 1'b0);
      add_event(KIND_TRAIN, 32'hFFFF_FFFF, 1'b0);
    end

    // A small working set of branches with their own bias, so counters and
    // chooser entries actually get trained and the two tables disagree.
    foreach (hot_pc[i]) begin
      hot_pc[i] = $urandom;
      bias[i]   = $urandom_range(0, 4);
    end

    while (branch_events.size() < EVENT_GOAL) begin
      pick = $urandom_range(0, 9);
      k    = $urandom_range(0, 15);
      if (pick <= 6) begin
        // Well-formed predict then train with a biased outcome.
        add_event(KIND_PREDICT, hot_pc[k], 1'($urandom_range(0, 1)));
        add_event(KIND_TRAIN, $urandom, $urandom_range(0, 3) < bias[k]);
      end else if (pick == 7) begin
        add_event(KIND_PREDICT, $urandom, 1'($urandom_range(0, 1)));
      end else if (pick == 8) begin
        // Stale retrain: two trains off the same lookup.
        add_event(KIND_TRAIN, $urandom, 1'($urandom_range(0, 1)));
        add_event(KIND_TRAIN, $urandom, 1'($urandom_range(0, 1)));
      end else begin
        // Same low bits, different high bits: aliases into the same entries.
        add_event(KIND_PREDICT, {19'($urandom_range(0, 32'h7FFFF)), hot_pc[k][12:0]},
                  1'($urandom_range(0, 1)));
      end
    end

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Wait for every event to move, every owed result to land, then drain.
    while (branch_events.size() > 0 || in_tvalid) @(posedge clk);
    while (predicted_dirs.size() > 0) @(posedge clk);
    repeat (DRAIN_LEN) @(posedge clk);

    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // Bound the run: reset sweep plus worst-case gaps and stalls, several times over.
  initial begin
    #1_000_000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule
